// ===== rtl/lpc_pkg.sv =====
// Shared types, constants and codes for the lift position controller.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package lpc_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int CODE_W     = 3;
    localparam int POWER_W    = 16;
    localparam int POS_W      = 16;
    localparam int RATE_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 10;

    // Divider geometry: dividend bits, divisor bits, quotient bits per cycle
    localparam int DIV_W          = 32;
    localparam int DIVISOR_W      = 16;
    localparam int DIV_BITS_CYCLE = 2;
    localparam int DIV_STEPS      = DIV_W / DIV_BITS_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Fixed-point constants
    localparam logic signed [POWER_W-1:0] POWER_ZERO  = 16'sd0;
    localparam logic signed [POWER_W-1:0] POWER_MOST_NEG = 16'sh8000;
    localparam logic signed [POWER_W-1:0] POWER_MIN   = -16'sd32767;
    localparam logic        [14:0]        MAG_MAX     = 15'd32767;
    localparam logic signed [POS_W-1:0]   BOTTOM_NEAR = 16'sd1024;
    localparam logic signed [POS_W:0]     CREEP_STEP  = 17'sd26;
    localparam logic signed [POS_W:0]     TARGET_MIN  = -17'sd32768;
    localparam logic signed [POS_W-1:0]   TARGET_TOP  = 16'sd32767;
    localparam logic signed [POS_W-1:0]   TARGET_LOW_CARGO  = 16'sd5376;
    localparam logic signed [POS_W-1:0]   TARGET_MID_CARGO  = 16'sd8704;
    localparam logic signed [POS_W-1:0]   TARGET_HIGH_CARGO = 16'sd12544;
    localparam logic signed [POS_W-1:0]   TARGET_HIGH_HATCH = 16'sd7168;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
    localparam logic [COUNT_W-1:0] DONE_HOLD = 10'd10;

    // Register reset values
    localparam logic [15:0] GAIN_RST          = 16'd102;
    localparam logic [11:0] TOLERANCE_RST     = 12'd128;
    localparam logic [15:0] MAX_SPEED_RST     = 16'd9216;
    localparam logic [15:0] OVER_MARGIN_RST   = 16'd2560;
    localparam logic [14:0] SLOW_ZONE_RST     = 15'd1280;
    localparam logic [15:0] SLOWEST_SPEED_RST = 16'd2048;
    localparam logic [9:0]  HOLD_LIMIT_RST    = 10'd100;
    localparam logic [9:0]  CALIB_WAIT_RST    = 10'd50;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_SET   = 2'd1,
        OP_STICK = 2'd2
    } t_opcode;

    typedef enum logic [CODE_W-1:0] {
        SP_BOTTOM     = 3'd0,
        SP_TOP        = 3'd1,
        SP_LOW_CARGO  = 3'd2,
        SP_MID_CARGO  = 3'd3,
        SP_HIGH_CARGO = 3'd4,
        SP_HIGH_HATCH = 3'd5,
        SP_STAY       = 3'd6
    } t_setpoint;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN          = 3'd0,
        CFG_TOLERANCE     = 3'd1,
        CFG_MAX_SPEED     = 3'd2,
        CFG_OVER_MARGIN   = 3'd3,
        CFG_SLOW_ZONE     = 3'd4,
        CFG_SLOWEST_SPEED = 3'd5,
        CFG_HOLD_LIMIT    = 3'd6,
        CFG_CALIB_WAIT    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_GAIN,
        S_MAG,
        S_RMUL,
        S_RDIV,
        S_OVER,
        S_SMUL,
        S_SDIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [15:0] gain;
        logic [11:0] tolerance;
        logic [15:0] max_speed;
        logic [15:0] over_margin;
        logic [14:0] slow_zone;
        logic [15:0] slowest_speed;
        logic [9:0]  hold_limit;
        logic [9:0]  calib_wait;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                       valid;
        logic signed [POWER_W-1:0]  motor_power;
        logic                       reset_encoder;
        logic                       done_res;
    } t_result;

endpackage

// ===== rtl/lpc_in_if.sv =====
// Input item channel: valid/ready handshake plus the item fields.
// Depends on lpc_pkg for field widths.
`timescale 1ns / 1ps

interface lpc_in_if;
    import lpc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic [CODE_W-1:0]          setpoint_code;
    logic signed [POWER_W-1:0]  stick_power;
    logic signed [POS_W-1:0]    position;
    logic signed [RATE_W-1:0]   rate;

    modport source (output valid, opcode, setpoint_code, stick_power, position, rate,
                    input ready);
    modport sink   (input valid, opcode, setpoint_code, stick_power, position, rate,
                    output ready);
endinterface

// ===== rtl/lpc_out_if.sv =====
// Result item channel: valid/ready handshake plus the result fields.
// Depends on lpc_pkg for field widths.
`timescale 1ns / 1ps

interface lpc_out_if;
    import lpc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [POWER_W-1:0]  motor_power;
    logic                       reset_encoder;
    logic                       done_res;

    modport source (output valid, motor_power, reset_encoder, done_res, input ready);
    modport sink   (input valid, motor_power, reset_encoder, done_res, output ready);
endinterface

// ===== rtl/lpc_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on lpc_pkg for widths.
`timescale 1ns / 1ps

interface lpc_cfg_if;
    import lpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lpc_cfg_regs.sv =====
// Configuration register file for the lift controller.
// Depends on lpc_pkg and lpc_cfg_if.
`timescale 1ns / 1ps

module lpc_cfg_regs (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpc_cfg_if.sink      i_cfg,
    output lpc_pkg::t_cfg o_cfg
);
    import lpc_pkg::*;

    t_cfg r_cfg;
    logic cfg_fire;

    // Always able to take a write
    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;
    assign o_cfg       = r_cfg;

    // Update the addressed register on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain          <= GAIN_RST;
            r_cfg.tolerance     <= TOLERANCE_RST;
            r_cfg.max_speed     <= MAX_SPEED_RST;
            r_cfg.over_margin   <= OVER_MARGIN_RST;
            r_cfg.slow_zone     <= SLOW_ZONE_RST;
            r_cfg.slowest_speed <= SLOWEST_SPEED_RST;
            r_cfg.hold_limit    <= HOLD_LIMIT_RST;
            r_cfg.calib_wait    <= CALIB_WAIT_RST;
        end else if (cfg_fire) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_GAIN:          r_cfg.gain          <= i_cfg.data;
                CFG_TOLERANCE:     r_cfg.tolerance     <= i_cfg.data[11:0];
                CFG_MAX_SPEED:     r_cfg.max_speed     <= i_cfg.data;
                CFG_OVER_MARGIN:   r_cfg.over_margin   <= i_cfg.data;
                CFG_SLOW_ZONE:     r_cfg.slow_zone     <= i_cfg.data[14:0];
                CFG_SLOWEST_SPEED: r_cfg.slowest_speed <= i_cfg.data;
                CFG_HOLD_LIMIT:    r_cfg.hold_limit    <= i_cfg.data[9:0];
                CFG_CALIB_WAIT:    r_cfg.calib_wait    <= i_cfg.data[9:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/lpc_div.sv =====
// Shared unsigned restoring divider, two quotient bits per cycle.
// Depends on lpc_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module lpc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lpc_pkg::t_div_req i_req,
    output lpc_pkg::t_div_rsp o_rsp
);
    import lpc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_den;
    logic [DIV_W-1:0]     r_quo;
    logic [DIVISOR_W-1:0] n_rem;
    logic [DIV_W-1:0]     n_quo;

    // Shift-subtract steps for one cycle
    always_comb begin
        logic [DIVISOR_W:0] shifted;
        logic               ge;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_BITS_CYCLE; k++) begin
            shifted = {n_rem, n_quo[DIV_W-1]};
            ge      = shifted >= {1'b0, r_den};
            if (ge) begin
                shifted = shifted - {1'b0, r_den};
            end
            n_rem = shifted[DIVISOR_W-1:0];
            n_quo = {n_quo[DIV_W-2:0], ge};
        end
    end

    // Load on start, iterate while busy, flag the last step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== rtl/lpc_ctrl.sv =====
// Sequencer and datapath: decodes items, holds controller state, runs the
// shared multiplier and drives the shared divider. Depends on lpc_pkg, lpc_in_if.
`timescale 1ns / 1ps

module lpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lpc_in_if.sink            i_in,
    input  lpc_pkg::t_cfg     i_cfg,
    output lpc_pkg::t_div_req o_div_req,
    input  lpc_pkg::t_div_rsp i_div_rsp,
    output lpc_pkg::t_result  o_res,
    input  logic              i_res_ready
);
    import lpc_pkg::*;

    t_state r_state, n_state;

    logic signed [POS_W-1:0]   r_target, n_target;
    logic                      r_auto, n_auto;
    logic [COUNT_W-1:0]        r_hold, n_hold;
    logic [COUNT_W-1:0]        r_still, n_still;
    logic signed [POS_W-1:0]   r_pos, n_pos;
    logic signed [RATE_W-1:0]  r_rate, n_rate;
    logic [POS_W:0]            r_aerr, n_aerr;
    logic                      r_neg, n_neg;
    logic [32:0]               r_prod, n_prod;
    logic [14:0]               r_mag, n_mag;
    logic [15:0]               r_cap, n_cap;
    logic [15:0]               r_scale, n_scale;
    logic signed [POWER_W-1:0] r_power, n_power;
    logic                      r_renc, n_renc;
    logic                      r_done, n_done;

    logic        in_fire;
    logic        stick_out;
    logic        tick_go;
    logic        skip;
    logic        ramp_mul;
    logic        over_cut;
    logic        over_scale;

    // Shared multiplier
    logic [16:0] mul_a;
    logic [15:0] mul_b;
    logic [32:0] mul_p;

    // Common terms
    logic signed [POS_W:0]    err;
    logic [POS_W:0]           aerr_cur;
    logic                     near;
    logic [COUNT_W-1:0]       hold_up;
    logic [COUNT_W-1:0]       still_up;
    logic [COUNT_W-1:0]       hold_n;
    logic [COUNT_W-1:0]       still_n;
    logic signed [16:0]       spd_diff;
    logic [15:0]              spd_adiff;
    logic [33:0]              rounded;
    logic [14:0]              mag_sat;
    logic                     lowering;
    logic [RATE_W-1:0]        arate;
    logic signed [RATE_W:0]   over;
    logic signed [POS_W:0]    creep;

    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign stick_out = (i_in.stick_power != POWER_ZERO) || !r_auto;
    assign tick_go   = r_auto;

    assign err      = {r_target[POS_W-1], r_target} - {r_pos[POS_W-1], r_pos};
    assign aerr_cur = err[POS_W] ? 17'(-err) : err;
    assign hold_up  = (r_hold == COUNT_MAX) ? r_hold : r_hold + 1'b1;
    assign still_up = (r_still == COUNT_MAX) ? r_still : r_still + 1'b1;
    assign near     = aerr_cur < {5'b0, i_cfg.tolerance};
    assign hold_n   = (near || r_rate == '0) ? hold_up : '0;
    assign still_n  = (r_rate == '0) ? still_up : '0;
    assign skip     = hold_n >= i_cfg.hold_limit;

    assign spd_diff  = $signed({1'b0, i_cfg.max_speed}) - $signed({1'b0, i_cfg.slowest_speed});
    assign spd_adiff = spd_diff[16] ? 16'(-spd_diff) : spd_diff[15:0];
    assign rounded   = {1'b0, r_prod} + 34'd1;
    assign mag_sat   = (rounded[33:1] > {18'b0, MAG_MAX}) ? MAG_MAX : rounded[15:1];
    assign lowering  = r_neg && (mag_sat != '0) && (r_pos < $signed({1'b0, i_cfg.slow_zone}));
    assign ramp_mul  = lowering && (r_pos > 16'sd0) && (spd_diff != 17'sd0);

    assign arate      = r_rate[RATE_W-1] ? RATE_W'(-r_rate) : r_rate;
    assign over       = $signed({1'b0, arate}) - $signed({3'b0, r_cap});
    assign over_cut   = over > $signed({3'b0, i_cfg.over_margin});
    assign over_scale = !over[RATE_W] && (over != '0);

    assign creep = {r_target[POS_W-1], r_target} - CREEP_STEP;

    // Route operands to the shared multiplier
    always_comb begin
        case (r_state)
            S_GAIN: begin
                mul_a = r_aerr;
                mul_b = i_cfg.gain;
            end
            S_RMUL: begin
                mul_a = {2'b0, r_pos[14:0]};
                mul_b = spd_adiff;
            end
            S_SMUL: begin
                mul_a = {2'b0, r_mag};
                mul_b = r_scale;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = {16'b0, mul_a} * {17'b0, mul_b};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_in.opcode))
                        OP_STICK: n_state = stick_out ? S_EMIT : S_IDLE;
                        OP_TICK:  n_state = tick_go ? S_ERR : S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ERR:  n_state = skip ? S_EMIT : S_GAIN;
            S_GAIN: n_state = S_MAG;
            S_MAG:  n_state = ramp_mul ? S_RMUL : S_OVER;
            S_RMUL: n_state = S_RDIV;
            S_RDIV: n_state = i_div_rsp.done ? S_OVER : S_RDIV;
            S_OVER: n_state = (!over_cut && over_scale) ? S_SMUL : S_EMIT;
            S_SMUL: n_state = S_SDIV;
            S_SDIV: n_state = i_div_rsp.done ? S_EMIT : S_SDIV;
            S_EMIT: n_state = i_res_ready ? S_IDLE : S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates per state
    always_comb begin
        n_target = r_target;
        n_auto   = r_auto;
        n_hold   = r_hold;
        n_still  = r_still;
        n_pos    = r_pos;
        n_rate   = r_rate;
        n_aerr   = r_aerr;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_mag    = r_mag;
        n_cap    = r_cap;
        n_scale  = r_scale;
        n_power  = r_power;
        n_renc   = r_renc;
        n_done   = r_done;
        o_div_req.start    = 1'b0;
        o_div_req.dividend = mul_p[DIV_W-1:0];
        o_div_req.divisor  = (r_state == S_RMUL) ? {1'b0, i_cfg.slow_zone}
                                                 : i_cfg.over_margin;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_opcode'(i_in.opcode))
                        OP_SET: begin
                            case (t_setpoint'(i_in.setpoint_code))
                                SP_BOTTOM: begin
                                    if (i_in.position < BOTTOM_NEAR && r_target <= 16'sd0) begin
                                        n_target = (creep < TARGET_MIN) ? POWER_MOST_NEG
                                                                        : creep[POS_W-1:0];
                                    end else begin
                                        n_target = '0;
                                    end
                                end
                                SP_TOP:        n_target = TARGET_TOP;
                                SP_LOW_CARGO:  n_target = TARGET_LOW_CARGO;
                                SP_MID_CARGO:  n_target = TARGET_MID_CARGO;
                                SP_HIGH_CARGO: n_target = TARGET_HIGH_CARGO;
                                SP_HIGH_HATCH: n_target = TARGET_HIGH_HATCH;
                                default: ;
                            endcase
                            n_hold  = '0;
                            n_still = '0;
                            n_auto  = 1'b1;
                        end
                        OP_STICK: begin
                            if (i_in.stick_power != POWER_ZERO) begin
                                n_auto = 1'b0;
                            end
                            n_power = (i_in.stick_power == POWER_MOST_NEG) ? POWER_MIN
                                                                           : i_in.stick_power;
                            n_renc  = 1'b0;
                            n_done  = 1'b0;
                        end
                        OP_TICK: begin
                            n_pos  = i_in.position;
                            n_rate = i_in.rate;
                            n_aerr = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // Error magnitude, counters and status flags
            S_ERR: begin
                n_neg   = err[POS_W];
                n_aerr  = aerr_cur;
                n_hold  = hold_n;
                n_still = still_n;
                n_done  = near || (hold_n > DONE_HOLD);
                n_renc  = (r_target <= 16'sd0) && (r_pos <= 16'sd0)
                          && (still_n >= i_cfg.calib_wait);
                n_power = POWER_ZERO;
            end
            S_GAIN: begin
                n_prod = mul_p;
            end
            // Round, clamp, pick the speed cap
            S_MAG: begin
                n_mag = mag_sat;
                n_cap = lowering ? i_cfg.slowest_speed : i_cfg.max_speed;
            end
            S_RMUL: begin
                o_div_req.start = 1'b1;
            end
            S_RDIV: begin
                if (i_div_rsp.done) begin
                    n_cap = spd_diff[16] ? i_cfg.slowest_speed - i_div_rsp.quotient[15:0]
                                         : i_cfg.slowest_speed + i_div_rsp.quotient[15:0];
                end
            end
            // Overspeed: cut, scale or pass
            S_OVER: begin
                if (over_cut) begin
                    n_power = POWER_ZERO;
                end else if (over_scale) begin
                    n_scale = i_cfg.over_margin - over[15:0];
                end else begin
                    n_power = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
                end
            end
            S_SMUL: begin
                o_div_req.start = 1'b1;
            end
            S_SDIV: begin
                if (i_div_rsp.done) begin
                    n_power = r_neg ? -$signed({1'b0, i_div_rsp.quotient[14:0]})
                                    : $signed({1'b0, i_div_rsp.quotient[14:0]});
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_target <= '0;
            r_auto   <= 1'b0;
            r_hold   <= '0;
            r_still  <= '0;
        end else begin
            r_state  <= n_state;
            r_target <= n_target;
            r_auto   <= n_auto;
            r_hold   <= n_hold;
            r_still  <= n_still;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_rate  <= n_rate;
        r_aerr  <= n_aerr;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_mag   <= n_mag;
        r_cap   <= n_cap;
        r_scale <= n_scale;
        r_power <= n_power;
        r_renc  <= n_renc;
        r_done  <= n_done;
    end

    assign o_res.valid         = (r_state == S_EMIT);
    assign o_res.motor_power   = r_power;
    assign o_res.reset_encoder = r_renc;
    assign o_res.done_res      = r_done;

endmodule

// ===== rtl/lift_position_controller_top.sv =====
// Top level of the lift position controller: config registers, sequencer,
// shared divider and the output register. Depends on lpc_pkg and the interfaces.
`timescale 1ns / 1ps

// Usage
//   i_in  : input items (opcode, setpoint_code, stick_power, position, rate).
//           A transfer happens when valid and ready are both high.
//   o_out : result items (motor_power, reset_encoder, done_res).
//   i_cfg : register writes by index; always ready. Write only while idle.
// Sequencing
//   Set-target items give no result. A stick item gives a result only when
//   its power is nonzero or manual mode is active. A tick item in automatic
//   mode steps the shared sequencer through error, gain, magnitude, overspeed
//   and emit; a long hold skips to emit and cuts power. Each division (bottom
//   ramp, overspeed scale) adds a state that loads the shared divider, which
//   retires two quotient bits a cycle, and one that waits for the quotient.
//   One item is in work at a time; ready is high only when the sequencer idles.
// Reset
//   i_rst_n (synchronous, active low) loads the register defaults, clears the
//   target, leaves automatic mode and zeroes the hold and still counters.
// Stalls
//   One output register holds a finished result; the next item is accepted
//   while it waits. If it is still occupied when a new result is ready, the
//   sequencer holds until the receiver takes the old one.

module lift_position_controller_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpc_in_if.sink    i_in,
    lpc_out_if.source o_out,
    lpc_cfg_if.sink   i_cfg
);
    import lpc_pkg::*;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_result  res;
    logic     res_load;

    logic                      r_out_valid;
    logic signed [POWER_W-1:0] r_out_power;
    logic                      r_out_renc;
    logic                      r_out_done;

    lpc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    lpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (cfg),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_res       (res),
        .i_res_ready (res_load)
    );

    // Take a result when the output register is free or being drained
    assign res_load = res.valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload until transfer
    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_out_power <= res.motor_power;
            r_out_renc  <= res.reset_encoder;
            r_out_done  <= res.done_res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.motor_power   = r_out_power;
    assign o_out.reset_encoder = r_out_renc;
    assign o_out.done_res      = r_out_done;

endmodule
